// ----- rtl/core/rsk_pkg.sv -----
// ----------------------------------------------------------------------------
// rsk_pkg: shared types and constants for the row sorter
// Field widths, register map codes and the sort geometry bundle.
// ----------------------------------------------------------------------------
package rsk_pkg;

    localparam int DATA_W = 32;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 4;
    localparam int KEY_W  = 3;
    localparam int CNT_W  = 7;
    localparam int TOT_W  = ROW_W + COL_W;

    localparam int MAX_ROWS_DEF = 8;
    localparam int MAX_COLS_DEF = 8;

    localparam int APB_AW = 4;

    // register indexes (byte address 4*index)
    localparam logic [1:0] REG_ROW_COUNT  = 2'd0;
    localparam logic [1:0] REG_COL_COUNT  = 2'd1;
    localparam logic [1:0] REG_KEY_COLUMN = 2'd2;

    // effective geometry, already clamped
    typedef struct packed {
        logic [ROW_W-1:0] rows;
        logic [COL_W-1:0] cols;
        logic [KEY_W-1:0] key;
        logic [TOT_W-1:0] total;
    } sort_cfg_t;

endpackage

// ----- rtl/core/row_sort_by_key_column.sv -----
// ----------------------------------------------------------------------------
// row_sort_by_key_column: descending row sort on one key column
// Loads a row-major matrix, exchange-sorts whole rows by the key column
// and streams the sorted matrix back out row-major.
//
//   channel  | direction | transaction payload
//   ---------+-----------+------------------------------------------------
//   s_       | in        | s_element_value (Q16.16)
//   m_       | out       | m_sorted_value (Q16.16), m_last_element
//   APB      | in/out    | row_count @0x0, col_count @0x4, key_column @0x8
//
// Load: one element per cycle. After the last element, the sort runs with
// one memory read pair and one signed comparator, comparing key pairs and
// swapping whole rows one column at a time, then streams the output element
// by element (stalled while m_ready is low). s_ready is low from the last element until
// the final output transaction is registered. Reset is synchronous; the
// element memory is not cleared.
// ----------------------------------------------------------------------------
module row_sort_by_key_column #(
    parameter int MAX_ROWS = rsk_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = rsk_pkg::MAX_COLS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsk_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_element_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [31:0]          m_sorted_value,
    output logic                        m_last_element
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [rsk_pkg::ROW_W-1:0] row_count_reg;
    logic [rsk_pkg::COL_W-1:0] col_count_reg;
    logic [rsk_pkg::KEY_W-1:0] key_column_reg;

    logic [1:0]                reg_idx;
    logic                      cfg_wr;
    rsk_pkg::sort_cfg_t        cfg;
    logic [rsk_pkg::COL_W-1:0] cols_m1;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [rsk_pkg::DATA_W-1:0]  wr_data;
    logic [AW-1:0]               rd_addr_a;
    logic [AW-1:0]               rd_addr_b;
    logic [rsk_pkg::DATA_W-1:0]  rd_data_a;
    logic [rsk_pkg::DATA_W-1:0]  rd_data_b;
    logic [rsk_pkg::DATA_W-1:0]  m_data;

    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg  <= rsk_pkg::ROW_W'(4);
            col_count_reg  <= rsk_pkg::COL_W'(3);
            key_column_reg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                rsk_pkg::REG_ROW_COUNT:  row_count_reg  <= pwdata[rsk_pkg::ROW_W-1:0];
                rsk_pkg::REG_COL_COUNT:  col_count_reg  <= pwdata[rsk_pkg::COL_W-1:0];
                rsk_pkg::REG_KEY_COLUMN: key_column_reg <= pwdata[rsk_pkg::KEY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rsk_pkg::REG_ROW_COUNT:  prdata = 32'(row_count_reg);
            rsk_pkg::REG_COL_COUNT:  prdata = 32'(col_count_reg);
            rsk_pkg::REG_KEY_COLUMN: prdata = 32'(key_column_reg);
            default:                 prdata = '0;
        endcase
    end

    // clamp sizes to 1..MAX and the key column to cols-1
    always_comb begin
        if (row_count_reg == '0) begin
            cfg.rows = rsk_pkg::ROW_W'(1);
        end else if (int'(row_count_reg) > MAX_ROWS) begin
            cfg.rows = rsk_pkg::ROW_W'(MAX_ROWS);
        end else begin
            cfg.rows = row_count_reg;
        end
        if (col_count_reg == '0) begin
            cfg.cols = rsk_pkg::COL_W'(1);
        end else if (int'(col_count_reg) > MAX_COLS) begin
            cfg.cols = rsk_pkg::COL_W'(MAX_COLS);
        end else begin
            cfg.cols = col_count_reg;
        end
        cols_m1 = cfg.cols - 1'b1;
        if (rsk_pkg::COL_W'(key_column_reg) > cols_m1) begin
            cfg.key = rsk_pkg::KEY_W'(cols_m1);
        end else begin
            cfg.key = key_column_reg;
        end
        cfg.total = rsk_pkg::TOT_W'(cfg.rows) * rsk_pkg::TOT_W'(cfg.cols);
    end

    rsk_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    rsk_seq #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_element_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .m_last    (m_last_element),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign m_sorted_value = m_data;

endmodule

// ----- rtl/core/rsk_store.sv -----
// ----------------------------------------------------------------------------
// rsk_store: element memory
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module rsk_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [rsk_pkg::DATA_W-1:0] wr_data,
    input  logic [AW-1:0]             rd_addr_a,
    input  logic [AW-1:0]             rd_addr_b,
    output logic [rsk_pkg::DATA_W-1:0] rd_data_a,
    output logic [rsk_pkg::DATA_W-1:0] rd_data_b
);

    logic [rsk_pkg::DATA_W-1:0] mem [DEPTH];
    logic [rsk_pkg::DATA_W-1:0] rd_a_reg;
    logic [rsk_pkg::DATA_W-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ----- rtl/core/rsk_seq.sv -----
// ----------------------------------------------------------------------------
// rsk_seq: load / sort / emit sequencer
// Drives the element memory, runs the exchange sort with one signed
// comparator and streams the sorted matrix out through an output register.
// ----------------------------------------------------------------------------
module rsk_seq #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rsk_pkg::sort_cfg_t         cfg,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [rsk_pkg::DATA_W-1:0] s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rsk_pkg::DATA_W-1:0] m_data,
    output logic                       m_last,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [rsk_pkg::DATA_W-1:0] wr_data,
    output logic [AW-1:0]              rd_addr_a,
    output logic [AW-1:0]              rd_addr_b,
    input  logic [rsk_pkg::DATA_W-1:0] rd_data_a,
    input  logic [rsk_pkg::DATA_W-1:0] rd_data_b
);

    // wide enough for row*cols+col with 4-bit operands
    localparam int XW = (AW > 9) ? AW : 9;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CMP_RD,
        ST_CMP,
        ST_SWP_RD,
        ST_SWP_WA,
        ST_SWP_WB,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    state_t                       state_reg;
    logic [rsk_pkg::CNT_W-1:0]    load_cnt_reg;
    logic [rsk_pkg::ROW_W-1:0]    i_reg;
    logic [rsk_pkg::ROW_W-1:0]    j_reg;
    logic [rsk_pkg::COL_W-1:0]    k_reg;
    logic [rsk_pkg::TOT_W-1:0]    n_reg;
    logic [rsk_pkg::DATA_W-1:0]   hold_reg;
    logic                         m_valid_reg;
    logic [rsk_pkg::DATA_W-1:0]   m_data_reg;
    logic                         m_last_reg;

    logic [rsk_pkg::CNT_W-1:0]    cnt_inc;
    logic [AW-1:0]                load_idx;
    logic [rsk_pkg::COL_W-1:0]    col_sel;
    logic [XW-1:0]                addr_a_w;
    logic [XW-1:0]                addr_b_w;
    logic [AW-1:0]                addr_a;
    logic [AW-1:0]                addr_b;
    logic                         do_swap;
    logic                         n_last;
    logic                         out_free;
    logic [rsk_pkg::ROW_W:0]      j_inc;
    logic [rsk_pkg::ROW_W:0]      i_inc2;

    assign cnt_inc = load_cnt_reg + 1'b1;

    always_comb begin
        if (int'(load_cnt_reg) >= DEPTH) begin
            load_idx = AW'(DEPTH - 1);
        end else begin
            load_idx = AW'(load_cnt_reg);
        end
    end

    assign col_sel  = (state_reg == ST_CMP_RD || state_reg == ST_CMP)
                      ? rsk_pkg::COL_W'(cfg.key) : k_reg;
    assign addr_a_w = XW'(i_reg) * XW'(cfg.cols) + XW'(col_sel);
    assign addr_b_w = XW'(j_reg) * XW'(cfg.cols) + XW'(col_sel);
    assign addr_a   = AW'(addr_a_w);
    assign addr_b   = AW'(addr_b_w);

    // the shared comparator: signed key order
    assign do_swap  = $signed(rd_data_a) < $signed(rd_data_b);

    assign n_last   = (n_reg + 1'b1) == cfg.total;
    assign out_free = !m_valid_reg || m_ready;
    assign j_inc    = {1'b0, j_reg} + 1'b1;
    assign i_inc2   = {1'b0, i_reg} + 2'd2;

    // memory port steering
    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = addr_a;
        wr_data   = rd_data_b;
        rd_addr_a = addr_a;
        rd_addr_b = addr_b;
        unique case (state_reg)
            ST_LOAD: begin
                wr_en   = s_valid;
                wr_addr = load_idx;
                wr_data = s_data;
            end
            ST_SWP_WA: begin
                wr_en   = 1'b1;
                wr_addr = addr_a;
                wr_data = rd_data_b;
            end
            ST_SWP_WB: begin
                wr_en   = 1'b1;
                wr_addr = addr_b;
                wr_data = hold_reg;
            end
            ST_EMIT_RD, ST_EMIT_LD: begin
                rd_addr_a = AW'(n_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            n_reg        <= '0;
            m_valid_reg  <= 1'b0;
            m_last_reg   <= 1'b0;
        end else begin
            // in ST_EMIT_LD the output register is reloaded below instead
            if (m_valid_reg && m_ready && state_reg != ST_EMIT_LD) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_valid) begin
                        if ({1'b0, cnt_inc} >= cfg.total) begin
                            load_cnt_reg <= '0;
                            i_reg        <= '0;
                            j_reg        <= rsk_pkg::ROW_W'(1);
                            n_reg        <= '0;
                            state_reg    <= (cfg.rows > rsk_pkg::ROW_W'(1))
                                            ? ST_CMP_RD : ST_EMIT_RD;
                        end else begin
                            load_cnt_reg <= cnt_inc;
                        end
                    end
                end
                ST_CMP_RD: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (do_swap) begin
                        k_reg     <= '0;
                        state_reg <= ST_SWP_RD;
                    end else if (j_inc < {1'b0, cfg.rows}) begin
                        j_reg     <= rsk_pkg::ROW_W'(j_inc);
                        state_reg <= ST_CMP_RD;
                    end else if (i_inc2 < {1'b0, cfg.rows}) begin
                        i_reg     <= i_reg + 1'b1;
                        j_reg     <= rsk_pkg::ROW_W'(i_inc2);
                        state_reg <= ST_CMP_RD;
                    end else begin
                        state_reg <= ST_EMIT_RD;
                    end
                end
                ST_SWP_RD: begin
                    state_reg <= ST_SWP_WA;
                end
                ST_SWP_WA: begin
                    hold_reg  <= rd_data_a;
                    state_reg <= ST_SWP_WB;
                end
                ST_SWP_WB: begin
                    if (k_reg + 1'b1 != cfg.cols) begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_SWP_RD;
                    end else if (j_inc < {1'b0, cfg.rows}) begin
                        j_reg     <= rsk_pkg::ROW_W'(j_inc);
                        state_reg <= ST_CMP_RD;
                    end else if (i_inc2 < {1'b0, cfg.rows}) begin
                        i_reg     <= i_reg + 1'b1;
                        j_reg     <= rsk_pkg::ROW_W'(i_inc2);
                        state_reg <= ST_CMP_RD;
                    end else begin
                        state_reg <= ST_EMIT_RD;
                    end
                end
                ST_EMIT_RD: begin
                    state_reg <= ST_EMIT_LD;
                end
                ST_EMIT_LD: begin
                    // read address still points at n, so the data stays valid
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= rd_data_a;
                        m_last_reg  <= n_last;
                        if (n_last) begin
                            n_reg     <= '0;
                            state_reg <= ST_LOAD;
                        end else begin
                            n_reg     <= n_reg + 1'b1;
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;

endmodule
